@@ design/nmea_pkg.sv @@
// Shared types and constants for the NMEA 0183 sentence checker.
// Holds character codes, verdict codes and parse phases; depends on nothing.

package nmea_pkg;

  // Characters of interest in a sentence.
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChNul    = 8'h00;

  // Shortest body that is accepted.
  localparam logic [7:0] MinBody  = 8'd6;
  localparam logic [7:0] CountMax = 8'hFF;

  // Reset value of the strict mode register.
  localparam logic StrictReset = 1'b1;

  // Verdict codes.
  localparam logic [2:0] ErrNone     = 3'd0;
  localparam logic [2:0] ErrNoDollar = 3'd1;
  localparam logic [2:0] ErrShort    = 3'd2;
  localparam logic [2:0] ErrMismatch = 3'd3;
  localparam logic [2:0] ErrZero     = 3'd4;
  localparam logic [2:0] ErrStrict   = 3'd5;
  localparam logic [2:0] ErrTerm     = 3'd6;
  localparam logic [2:0] ErrTrunc    = 3'd7;

  // Parse phases.
  localparam logic [2:0] PhStart    = 3'd0;
  localparam logic [2:0] PhBody     = 3'd1;
  localparam logic [2:0] PhHex      = 3'd2;
  localparam logic [2:0] PhTail     = 3'd3;
  localparam logic [2:0] PhTailCr   = 3'd4;
  localparam logic [2:0] PhTailDone = 3'd5;
  localparam logic [2:0] PhEnded    = 3'd6;

  // One verdict as it leaves the block.
  typedef struct packed {
    logic [7:0] body_length;
    logic [7:0] computed_checksum;
    logic [2:0] error_code;
    logic       sentence_ok;
  } result_t;

endpackage

@@ design/nmea_sentence_checker.sv @@
// Top level of the NMEA 0183 sentence checker: per-byte parser and verdict output.
// Depends on nmea_pkg for character codes, verdict codes, phases and the result type.
//
// Channel   Direction  Word contents
// s_axis    in         tdata = data_byte, tlast = last_byte
// m_axis    out        tuser = sentence_ok, tdata = error_code, computed_checksum, body_length
// cfg       in         cfg_data = strict_mode
//
// One byte is taken every cycle while the skid stage is empty; the parse state is updated
// by a single combinational step between the state registers and the result register.
// The verdict of the byte flagged last is registered in the result register or skid stage.
// The result register is backed by a one-word skid stage, so input stalls only when both
// hold a verdict that has not been taken.
// Reset clears the parse state, both output stages and sets strict mode.

module nmea_sentence_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input bytes
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // last_byte
  // Verdicts
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [2:0] error_code, [10:3] computed_checksum,
                                        // [18:11] body_length, [23:19] zero
  output logic        m_axis_tuser_o,   // sentence_ok
  // Configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i        // strict_mode
);

  // Value of a hex digit, with a flag for a valid digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // End of string: returns the next phase and first error.
  function automatic logic [5:0] end_string(input logic [2:0] ph, input logic [2:0] er,
                                            input logic [7:0] cnt, input logic strict);
    logic [5:0] r;
    r = {nmea_pkg::PhEnded, er};
    unique case (ph)
      nmea_pkg::PhStart: r = {nmea_pkg::PhEnded, nmea_pkg::ErrNoDollar};
      nmea_pkg::PhBody: begin
        if (cnt < nmea_pkg::MinBody) begin
          r = {nmea_pkg::PhEnded, nmea_pkg::ErrShort};
        end else if (strict) begin
          r = {nmea_pkg::PhEnded, nmea_pkg::ErrStrict};
        end
      end
      nmea_pkg::PhHex:    r = {nmea_pkg::PhEnded, nmea_pkg::ErrTrunc};
      nmea_pkg::PhTailCr: r = {nmea_pkg::PhEnded, nmea_pkg::ErrTerm};
      default:            r = {nmea_pkg::PhEnded, er};
    endcase
    return r;
  endfunction

  // Configuration register, always writable.
  logic strict_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strict_q <= nmea_pkg::StrictReset;
    end else if (cfg_valid_i) begin
      strict_q <= cfg_data_i;
    end
  end

  // Parse state.
  logic [2:0] phase_q, phase_d;
  logic [7:0] xor_q, xor_d;
  logic [7:0] count_q, count_d;
  logic [1:0] seen_q, seen_d;
  logic [7:0] hexval_q, hexval_d;
  logic       hstop_q, hstop_d;
  logic [2:0] err_q, err_d;

  logic       in_acc;
  logic       push;
  nmea_pkg::result_t res_new;

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign push   = in_acc && s_axis_tlast_i;

  // One parse step for the incoming byte, then the verdict if it is the last one.
  always_comb begin
    logic [7:0] c;
    logic [4:0] hd;
    logic [5:0] es;
    logic [2:0] ph;
    logic [2:0] er;
    logic [7:0] xr;
    logic [7:0] cnt;
    logic [1:0] sn;
    logic [7:0] hv;
    logic       hs;

    c   = s_axis_tdata_i;
    hd  = hex_digit(c);
    ph  = phase_q;
    er  = err_q;
    xr  = xor_q;
    cnt = count_q;
    sn  = seen_q;
    hv  = hexval_q;
    hs  = hstop_q;
    es  = 6'd0;

    if (ph != nmea_pkg::PhEnded) begin
      if (c == nmea_pkg::ChNul) begin
        es = end_string(ph, er, cnt, strict_q);
        ph = es[5:3];
        er = es[2:0];
      end else begin
        unique case (ph)
          nmea_pkg::PhStart: begin
            if (c == nmea_pkg::ChDollar) begin
              ph = nmea_pkg::PhBody;
            end else begin
              ph = nmea_pkg::PhEnded;
              er = nmea_pkg::ErrNoDollar;
            end
          end
          nmea_pkg::PhBody: begin
            if (c == nmea_pkg::ChStar) begin
              if (cnt < nmea_pkg::MinBody) begin
                ph = nmea_pkg::PhEnded;
                er = nmea_pkg::ErrShort;
              end else begin
                ph = nmea_pkg::PhHex;
              end
            end else begin
              xr = xr ^ c;
              if (cnt != nmea_pkg::CountMax) begin
                cnt = cnt + 8'd1;
              end
            end
          end
          nmea_pkg::PhHex: begin
            if (!hs && hd[4]) begin
              hv = {hv[3:0], hd[3:0]};
            end else begin
              hs = 1'b1;
            end
            // The field closes on its second character.
            if (sn != 2'd0) begin
              if (hv == 8'd0) begin
                ph = nmea_pkg::PhEnded;
                er = nmea_pkg::ErrZero;
              end else if (hv != xr) begin
                ph = nmea_pkg::PhEnded;
                er = nmea_pkg::ErrMismatch;
              end else begin
                ph = nmea_pkg::PhTail;
              end
            end
            sn = sn + 2'd1;
          end
          nmea_pkg::PhTail: begin
            if (c == nmea_pkg::ChLf) begin
              ph = nmea_pkg::PhTailDone;
            end else if (c == nmea_pkg::ChCr) begin
              ph = nmea_pkg::PhTailCr;
            end else begin
              ph = nmea_pkg::PhEnded;
              er = nmea_pkg::ErrTerm;
            end
          end
          nmea_pkg::PhTailCr: begin
            if (c == nmea_pkg::ChLf) begin
              ph = nmea_pkg::PhTailDone;
            end else begin
              ph = nmea_pkg::PhEnded;
              er = nmea_pkg::ErrTerm;
            end
          end
          nmea_pkg::PhTailDone: begin
            ph = nmea_pkg::PhEnded;
            er = nmea_pkg::ErrTerm;
          end
          default: begin
            ph = nmea_pkg::PhEnded;
          end
        endcase
      end
    end

    // Close the sentence on the last byte.
    if (s_axis_tlast_i && ph != nmea_pkg::PhEnded) begin
      es = end_string(ph, er, cnt, strict_q);
      ph = es[5:3];
      er = es[2:0];
    end

    res_new.sentence_ok       = (er == nmea_pkg::ErrNone);
    res_new.error_code        = er;
    res_new.computed_checksum = xr;
    res_new.body_length       = cnt;

    if (s_axis_tlast_i) begin
      phase_d  = nmea_pkg::PhStart;
      err_d    = nmea_pkg::ErrNone;
      xor_d    = 8'd0;
      count_d  = 8'd0;
      seen_d   = 2'd0;
      hexval_d = 8'd0;
      hstop_d  = 1'b0;
    end else begin
      phase_d  = ph;
      err_d    = er;
      xor_d    = xr;
      count_d  = cnt;
      seen_d   = sn;
      hexval_d = hv;
      hstop_d  = hs;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= nmea_pkg::PhStart;
      err_q    <= nmea_pkg::ErrNone;
      xor_q    <= 8'd0;
      count_q  <= 8'd0;
      seen_q   <= 2'd0;
      hexval_q <= 8'd0;
      hstop_q  <= 1'b0;
    end else if (in_acc) begin
      phase_q  <= phase_d;
      err_q    <= err_d;
      xor_q    <= xor_d;
      count_q  <= count_d;
      seen_q   <= seen_d;
      hexval_q <= hexval_d;
      hstop_q  <= hstop_d;
    end
  end

  // Result register with a one-word skid stage behind it.
  logic              out_valid_q;
  logic              skid_valid_q;
  nmea_pkg::result_t out_q;
  nmea_pkg::result_t skid_q;
  logic              pop;

  assign pop             = out_valid_q && m_axis_tready_i;
  assign s_axis_tready_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_q <= res_new;
      end else begin
        skid_q <= res_new;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.sentence_ok;
  assign m_axis_tdata_o  = {5'd0, out_q.body_length, out_q.computed_checksum,
                            out_q.error_code};

  // The skid stage only fills behind a full result register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a word while the result register is empty");

  // A delivered verdict is ok exactly when its code is none.
  a_ok_matches_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == (m_axis_tdata_o[2:0] == nmea_pkg::ErrNone)))
    else $error("sentence_ok disagrees with error_code");

  // A sentence closed by its last byte leaves the parser ready for a new one.
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (phase_q == nmea_pkg::PhStart && err_q == nmea_pkg::ErrNone
              && count_q == 8'd0))
    else $error("parse state not cleared after the last byte");

endmodule
